>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

>>> sv/chash_pkg.sv
// Types and constants of the chained hash table.
`default_nettype none
package chash_pkg;

    localparam logic [31:0] HASH_MULT         = 32'd1000000007;
    localparam int          DEF_BUCKET_COUNT  = 1024;
    localparam int          DEF_POOL_NODES    = 4096;

    typedef enum logic {
        OP_SET = 1'b0,
        OP_GET = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_FIX,
        ST_LOOKUP,
        ST_HEAD,
        ST_NODE
    } t_state;

    typedef struct packed {
        t_op                op;
        logic signed [7:0]  key_byte;
        logic               key_last;
        logic signed [31:0] set_data;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] found_data;
        logic signed [31:0] key_hash;
    } t_res;

endpackage
`default_nettype wire

>>> sv/chained_hash_table_core.sv
// Chained hash table: byte-serial key hashing, bucket heads and node pool in RAM.
`default_nettype none
`include "assert_macros.svh"

// Key bytes are taken one per cycle while busy is low; each byte updates the
// running hash hash = hash * 1000000007 + byte. The byte marked last raises
// busy while the set or get runs against a single-port bucket-head RAM and a
// node-pool RAM with separate read and write addresses, both read through a
// register. A set reads the bucket head, then writes the new node and the head;
// a set refused for a full pool ends after the lookup; a get reads the head and
// then walks the chain one node read per cycle until the hash matches or the
// chain ends. With a bucket count that is not a power of two, reducing the hash
// to a bucket adds the ST_MOD steps (4 remainder bits per cycle), then the
// ST_FIX sign correction. The result shows on o_res for exactly one cycle with
// o_res_strobe high; the receiver cannot stall it, and busy is low again in that
// cycle. After reset the block stays busy while it clears the bucket-head RAM.
module chained_hash_table_core
    import chash_pkg::*;
#(
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
    parameter int POOL_NODES   = DEF_POOL_NODES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_cmd i_cmd,
    output logic      o_res_strobe,
    output t_res      o_res
);

    localparam int BKT_W   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int NODE_W  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int CNT_W   = $clog2(POOL_NODES + 1);
    localparam int REM_W   = BKT_W + 1;
    localparam bit IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
    localparam int DIGIT_W = 4;
    localparam int MOD_STEPS = 32 / DIGIT_W;
    localparam logic [63:0]      K64   = 64'h1_0000_0000 % BUCKET_COUNT;
    localparam logic [REM_W-1:0] K_R   = K64[REM_W-1:0];
    localparam logic [REM_W-1:0] BC_R  = REM_W'(BUCKET_COUNT);
    localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKET_COUNT - 1);
    localparam logic [CNT_W-1:0] POOL_C   = CNT_W'(POOL_NODES);
    localparam logic [2:0]       STEP_LAST = 3'(MOD_STEPS - 1);

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] idx;
    } t_head_word;

    typedef struct packed {
        logic [31:0]       hash;
        logic [31:0]       data;
        logic              nvalid;
        logic [NODE_W-1:0] next;
    } t_node_word;

    // Storage
    t_head_word mem_head [BUCKET_COUNT];
    t_node_word mem_node [POOL_NODES];

    // Registers
    t_state           r_state, n_state;
    logic [31:0]      r_run, n_run;
    logic [31:0]      r_hash, n_hash;
    t_op              r_op, n_op;
    logic [31:0]      r_data, n_data;
    logic [BKT_W-1:0] r_bucket, n_bucket;
    logic [31:0]      r_mod, n_mod;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [2:0]       r_step, n_step;
    logic [BKT_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0] r_used, n_used;
    logic             r_res_strobe, n_res_strobe;
    t_res             r_res, n_res;
    t_head_word       r_head_q;
    t_node_word       r_node_q;

    // Memory controls
    logic              head_we, head_re;
    logic [BKT_W-1:0]  head_addr;
    t_head_word        head_wdata;
    logic              node_we, node_re;
    logic [NODE_W-1:0] node_raddr;
    t_node_word        node_wdata;

    // Datapath helpers
    logic             accept;
    logic             pool_full;
    logic [31:0]      hash_new;
    logic [REM_W-1:0] rem_v;
    logic [REM_W-1:0] fix_v;

    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign pool_full = (r_used == POOL_C);

    // Advance the running hash by one signed byte
    assign hash_new = (r_run * HASH_MULT) + {{24{i_cmd.key_byte[7]}}, i_cmd.key_byte};

    // Fold four hash bits into the remainder
    always_comb begin
        rem_v = r_rem;
        for (int i = 0; i < DIGIT_W; i++) begin
            rem_v = {rem_v[REM_W-2:0], r_mod[31-i]};
            if (rem_v >= BC_R) begin
                rem_v = rem_v - BC_R;
            end
        end
    end

    // Correct the unsigned remainder for a negative hash
    always_comb begin
        if (!r_hash[31]) begin
            fix_v = r_rem;
        end else if (r_rem >= K_R) begin
            fix_v = r_rem - K_R;
        end else begin
            fix_v = r_rem + (BC_R - K_R);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == BKT_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && i_cmd.key_last) begin
                    n_state = IS_POW2 ? ST_LOOKUP : ST_MOD;
                end
            end
            ST_MOD: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (r_op == OP_SET && pool_full) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (r_op == OP_GET && r_head_q.valid) begin
                    n_state = ST_NODE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_NODE: begin
                if (r_node_q.hash != r_hash && r_node_q.nvalid) begin
                    n_state = ST_NODE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_run        = r_run;
        n_hash       = r_hash;
        n_op         = r_op;
        n_data       = r_data;
        n_bucket     = r_bucket;
        n_mod        = r_mod;
        n_rem        = r_rem;
        n_step       = r_step;
        n_clr        = r_clr;
        n_used       = r_used;
        n_res_strobe = 1'b0;
        n_res        = r_res;
        head_we      = 1'b0;
        head_re      = 1'b0;
        head_addr    = r_bucket;
        head_wdata   = '{valid: 1'b1, idx: r_used[NODE_W-1:0]};
        node_we      = 1'b0;
        node_re      = 1'b0;
        node_raddr   = r_node_q.next;
        node_wdata   = '{hash: r_hash, data: r_data, nvalid: r_head_q.valid,
                         next: r_head_q.idx};
        case (r_state)
            ST_CLEAR: begin
                head_we    = 1'b1;
                head_addr  = r_clr;
                head_wdata = '0;
                n_clr      = r_clr + 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_cmd.key_last) begin
                        n_run    = '0;
                        n_hash   = hash_new;
                        n_op     = i_cmd.op;
                        n_data   = i_cmd.set_data;
                        n_bucket = hash_new[BKT_W-1:0];
                        n_mod    = hash_new;
                        n_rem    = '0;
                        n_step   = '0;
                    end else begin
                        n_run = hash_new;
                    end
                end
            end
            ST_MOD: begin
                n_rem  = rem_v;
                n_mod  = {r_mod[31-DIGIT_W:0], {DIGIT_W{1'b0}}};
                n_step = r_step + 1'b1;
            end
            ST_FIX: begin
                n_bucket = fix_v[BKT_W-1:0];
            end
            ST_LOOKUP: begin
                if (r_op == OP_SET && pool_full) begin
                    n_res_strobe = 1'b1;
                    n_res        = '{status: STAT_FULL, found_data: '0, key_hash: r_hash};
                end else begin
                    head_re = 1'b1;
                end
            end
            ST_HEAD: begin
                if (r_op == OP_SET) begin
                    // Push the new node on the head of its chain
                    node_we      = 1'b1;
                    head_we      = 1'b1;
                    n_used       = r_used + 1'b1;
                    n_res_strobe = 1'b1;
                    n_res        = '{status: STAT_OK, found_data: '0, key_hash: r_hash};
                end else if (r_head_q.valid) begin
                    node_re    = 1'b1;
                    node_raddr = r_head_q.idx;
                end else begin
                    n_res_strobe = 1'b1;
                    n_res        = '{status: STAT_MISS, found_data: '0, key_hash: r_hash};
                end
            end
            ST_NODE: begin
                if (r_node_q.hash == r_hash) begin
                    n_res_strobe = 1'b1;
                    n_res        = '{status: STAT_OK, found_data: r_node_q.data,
                                     key_hash: r_hash};
                end else if (r_node_q.nvalid) begin
                    node_re = 1'b1;
                end else begin
                    n_res_strobe = 1'b1;
                    n_res        = '{status: STAT_MISS, found_data: '0, key_hash: r_hash};
                end
            end
            default: begin
                n_res_strobe = 1'b0;
            end
        endcase
    end

    // Bucket-head RAM
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            mem_head[head_addr] <= head_wdata;
        end
        if (head_re) begin
            r_head_q <= mem_head[head_addr];
        end
    end

    // Node-pool RAM
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            mem_node[r_used[NODE_W-1:0]] <= node_wdata;
        end
        if (node_re) begin
            r_node_q <= mem_node[node_raddr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_run        <= '0;
            r_clr        <= '0;
            r_used       <= '0;
            r_res_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_run        <= n_run;
            r_clr        <= n_clr;
            r_used       <= n_used;
            r_res_strobe <= n_res_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hash   <= n_hash;
        r_op     <= n_op;
        r_data   <= n_data;
        r_bucket <= n_bucket;
        r_mod    <= n_mod;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_res    <= n_res;
    end

    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

    // Checks
    `ASSERT_ALWAYS(a_used_bound, r_used <= POOL_C, "node count beyond pool size")
    `ASSERT_IMPLY(a_full_only_when_full, r_res_strobe && r_res.status == STAT_FULL,
        pool_full, "set refused while pool has room")
    `ASSERT_IMPLY(a_fail_no_data, r_res_strobe && r_res.status != STAT_OK,
        r_res.found_data == 0, "failed transaction returned data")
    `ASSERT_IMPLY(a_strobe_after_busy, r_res_strobe, $past(r_state) != ST_IDLE,
        "result without a pending transaction")

endmodule
`default_nettype wire
